>>> sv/wsce_pkg.sv
// Shared types, constants and helpers for the WebSocket client frame encoder.
package wsce_pkg;

    localparam int LEN_W = 63;
    localparam int KEY_W = 32;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    localparam logic [LEN_W-1:0] LEN7_MAX  = LEN_W'(125);
    localparam logic [LEN_W-1:0] LEN16_MAX = LEN_W'(65535);
    localparam logic [6:0]       LEN16_CODE = 7'd126;
    localparam logic [6:0]       LEN64_CODE = 7'd127;
    localparam logic [7:0]       MASK_BIT   = 8'h80;

    // Length encoding classes of the header
    localparam logic [1:0] LEN_CLASS_7  = 2'd0;
    localparam logic [1:0] LEN_CLASS_16 = 2'd1;
    localparam logic [1:0] LEN_CLASS_64 = 2'd2;

    // Bytes of a header burst after its first byte
    localparam int REST_BYTES = 13;
    localparam int REST_CW    = $clog2(REST_BYTES + 1);
    localparam logic [REST_CW-1:0] REST_CNT_7  = REST_CW'(5);
    localparam logic [REST_CW-1:0] REST_CNT_16 = REST_CW'(7);
    localparam logic [REST_CW-1:0] REST_CNT_64 = REST_CW'(13);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             req_type;
        logic             final_flag;
        logic [3:0]       frame_opcode;
        logic [LEN_W-1:0] payload_length;
        logic [KEY_W-1:0] masking_key;
        logic [7:0]       data_byte;
    } wsce_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       header_flag;
        logic       end_of_frame;
    } wsce_out_t;

    // Work handed from the front end to the back end
    typedef struct packed {
        logic             is_hdr;
        logic             eof;
        logic [7:0]       data;
        logic [1:0]       len_class;
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
    } wsce_cmd_t;

    function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                            input logic [1:0] idx);
        logic [4:0] shift;
        shift = {~idx, 3'b000};
        return 8'(key >> shift);
    endfunction

endpackage

>>> sv/wsce_front.sv
// Front end: accepts items, tracks the open frame and queues header or masked-byte work.
module wsce_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  wsce_pkg::wsce_in_t  item,
    output logic                push_valid,
    input  logic                push_ready,
    output wsce_pkg::wsce_cmd_t push_cmd
);
    import wsce_pkg::*;

    logic             frame_open_reg, frame_open_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [1:0]       kpos_reg, kpos_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic             accept;
    logic             is_start;
    logic             last_byte;

    assign item_ready = push_ready;
    assign accept     = item_valid && item_ready;
    assign is_start   = (item.req_type == REQ_START);
    assign last_byte  = (remain_reg == LEN_W'(1));
    // drop payload words that arrive outside a frame
    assign push_valid = item_valid && (is_start || frame_open_reg);

    always_comb
    begin
        push_cmd = '0;
        if (is_start)
        begin
            push_cmd.is_hdr = 1'b1;
            push_cmd.data   = {item.final_flag, 3'b000, item.frame_opcode};
            push_cmd.eof    = (item.payload_length == '0);
            push_cmd.len    = item.payload_length;
            push_cmd.key    = item.masking_key;
            if (item.payload_length <= LEN7_MAX)
                push_cmd.len_class = LEN_CLASS_7;
            else if (item.payload_length <= LEN16_MAX)
                push_cmd.len_class = LEN_CLASS_16;
            else
                push_cmd.len_class = LEN_CLASS_64;
        end
        else
        begin
            push_cmd.is_hdr = 1'b0;
            push_cmd.data   = item.data_byte ^ key_byte(key_reg, kpos_reg);
            push_cmd.eof    = last_byte;
        end
    end

    always_comb
    begin
        frame_open_next = frame_open_reg;
        key_next        = key_reg;
        kpos_next       = kpos_reg;
        remain_next     = remain_reg;
        if (accept)
        begin
            if (is_start)
            begin
                key_next        = item.masking_key;
                kpos_next       = 2'd0;
                remain_next     = item.payload_length;
                frame_open_next = (item.payload_length != '0);
            end
            else if (frame_open_reg)
            begin
                kpos_next       = kpos_reg + 2'd1;
                remain_next     = remain_reg - LEN_W'(1);
                frame_open_next = !last_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            key_reg        <= '0;
            kpos_reg       <= 2'd0;
            remain_reg     <= '0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            key_reg        <= key_next;
            kpos_reg       <= kpos_next;
            remain_reg     <= remain_next;
        end
    end

`ifndef SYNTHESIS
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> (remain_reg != '0))
        else $error("open frame with no bytes remaining");
`endif

endmodule

>>> sv/wsce_queue.sv
// Short work queue between the front and back ends.
module wsce_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  wsce_pkg::wsce_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output wsce_pkg::wsce_cmd_t pop_cmd
);
    import wsce_pkg::*;

    wsce_cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                push_fire;
    logic                pop_fire;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + QUEUE_CW'(1);
            2'b01:   count_next = count_reg - QUEUE_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && pop_fire) |=> $stable(count_reg))
        else $error("queue count moved on simultaneous push and pop");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

>>> sv/wsce_back.sv
// Back end: serialises header bursts and masked bytes into the output register.
module wsce_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  wsce_pkg::wsce_cmd_t pop_cmd,
    output logic                result_valid,
    input  logic                result_ready,
    output wsce_pkg::wsce_out_t result
);
    import wsce_pkg::*;

    logic [REST_BYTES-1:0][7:0] rest_reg, rest_next, load_rest;
    logic [REST_CW-1:0]         cnt_reg, cnt_next, load_cnt;
    logic                       hdr_eof_reg, hdr_eof_next;
    logic                       ovalid_reg, ovalid_next;
    wsce_out_t                  out_reg, out_next;
    logic                       out_free;
    logic                       burst;
    logic [LEN_W:0]             len64;

    assign out_free     = !ovalid_reg || result_ready;
    assign burst        = (cnt_reg != '0);
    assign pop_ready    = out_free && !burst;
    assign result_valid = ovalid_reg;
    assign result       = out_reg;
    assign len64        = {1'b0, pop_cmd.len};

    // header bytes after the opcode byte, in send order from element 0
    always_comb
    begin
        load_rest = '0;
        case (pop_cmd.len_class)
            LEN_CLASS_7:
            begin
                load_rest[0] = MASK_BIT | {1'b0, pop_cmd.len[6:0]};
                for (int i = 0; i < 4; i++)
                    load_rest[1 + i] = key_byte(pop_cmd.key, 2'(i));
                load_cnt = REST_CNT_7;
            end
            LEN_CLASS_16:
            begin
                load_rest[0] = MASK_BIT | {1'b0, LEN16_CODE};
                load_rest[1] = pop_cmd.len[15:8];
                load_rest[2] = pop_cmd.len[7:0];
                for (int i = 0; i < 4; i++)
                    load_rest[3 + i] = key_byte(pop_cmd.key, 2'(i));
                load_cnt = REST_CNT_16;
            end
            default:
            begin
                load_rest[0] = MASK_BIT | {1'b0, LEN64_CODE};
                for (int i = 0; i < 8; i++)
                    load_rest[1 + i] = len64[LEN_W - 8*i -: 8];
                for (int i = 0; i < 4; i++)
                    load_rest[9 + i] = key_byte(pop_cmd.key, 2'(i));
                load_cnt = REST_CNT_64;
            end
        endcase
    end

    always_comb
    begin
        rest_next    = rest_reg;
        cnt_next     = cnt_reg;
        hdr_eof_next = hdr_eof_reg;
        ovalid_next  = ovalid_reg;
        out_next     = out_reg;
        if (out_free)
        begin
            if (burst)
            begin
                ovalid_next           = 1'b1;
                out_next.out_byte     = rest_reg[0];
                out_next.header_flag  = 1'b1;
                out_next.end_of_frame = (cnt_reg == REST_CW'(1)) && hdr_eof_reg;
                rest_next             = {8'h00, rest_reg[REST_BYTES-1:1]};
                cnt_next              = cnt_reg - REST_CW'(1);
            end
            else if (pop_valid)
            begin
                ovalid_next           = 1'b1;
                out_next.out_byte     = pop_cmd.data;
                out_next.header_flag  = pop_cmd.is_hdr;
                out_next.end_of_frame = !pop_cmd.is_hdr && pop_cmd.eof;
                if (pop_cmd.is_hdr)
                begin
                    rest_next    = load_rest;
                    cnt_next     = load_cnt;
                    hdr_eof_next = pop_cmd.eof;
                end
            end
            else
            begin
                ovalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg    <= rest_next;
        hdr_eof_reg <= hdr_eof_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef SYNTHESIS
    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= REST_CNT_64)
        else $error("header burst count out of range");

    a_burst_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        burst |-> ovalid_reg)
        else $error("header burst running with no word held");
`endif

endmodule

>>> sv/websocket_client_frame_encoder.sv
// Top level of the WebSocket client frame encoder.
// A start word yields a masked client frame header of 6, 8 or 14 bytes (7-bit,
// 16-bit or 64-bit length form, each followed by the four key bytes), sent one
// byte per cycle unless the output stalls, from a header shift register in the
// back end; each payload word inside an open frame yields one masked byte, and
// words pass at one per cycle unless a stall or a header burst holds them. The
// front end tracks the open frame and keeps taking words while its four-entry
// work queue has room, so input and output stall independently. Payload words
// outside an open frame are taken and dropped.
module websocket_client_frame_encoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  wsce_pkg::wsce_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output wsce_pkg::wsce_out_t result
);
    import wsce_pkg::*;

    logic      push_valid;
    logic      push_ready;
    wsce_cmd_t push_cmd;
    logic      pop_valid;
    logic      pop_ready;
    wsce_cmd_t pop_cmd;

    wsce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    wsce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    wsce_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the WebSocket client frame encoder.
module testbench;

    import wsce_pkg::*;

    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;
    localparam logic [3:0] OPC_RSV_F  = 4'hF;

    localparam int IDLE_PCT   = 7;
    localparam int WORD_COUNT = 430;

    // Tracks the open frame and the encoded bytes still owed by the block
    class frame_tracker;
        bit               frame_live;
        logic [KEY_W-1:0] frame_key;
        logic [1:0]       lane;
        logic [LEN_W-1:0] left;
        wsce_out_t        owed_bytes[$];
        int               fails;

        function logic [7:0] key_lane(logic [KEY_W-1:0] k, logic [1:0] i);
            return k[(31 - 8 * int'(i)) -: 8];
        endfunction

        function void owe(logic [7:0] b, logic hdr, logic eof);
            wsce_out_t r;
            r.out_byte     = b;
            r.header_flag  = hdr;
            r.end_of_frame = eof;
            owed_bytes.push_back(r);
        endfunction

        // Returns the number of bytes the word produces
        function int note_word(wsce_in_t w);
            int before_cnt;
            before_cnt = owed_bytes.size();
            if (w.req_type == REQ_START) begin
                owe({w.final_flag, 3'b000, w.frame_opcode}, 1'b1, 1'b0);
                if (w.payload_length <= LEN7_MAX) begin
                    owe(MASK_BIT | {1'b0, w.payload_length[6:0]}, 1'b1, 1'b0);
                end
                else if (w.payload_length <= LEN16_MAX) begin
                    owe(MASK_BIT | {1'b0, LEN16_CODE}, 1'b1, 1'b0);
                    owe(w.payload_length[15:8], 1'b1, 1'b0);
                    owe(w.payload_length[7:0], 1'b1, 1'b0);
                end
                else begin
                    owe(MASK_BIT | {1'b0, LEN64_CODE}, 1'b1, 1'b0);
                    for (int i = 7; i >= 0; i--)
                        owe(8'({1'b0, w.payload_length} >> (8 * i)), 1'b1, 1'b0);
                end
                for (int i = 0; i < 4; i++)
                    owe(key_lane(w.masking_key, 2'(i)), 1'b1,
                        (i == 3) && (w.payload_length == '0));
                frame_key  = w.masking_key;
                lane       = 2'd0;
                left       = w.payload_length;
                frame_live = (w.payload_length != '0);
            end
            else if (frame_live) begin
                left = left - LEN_W'(1);
                owe(w.data_byte ^ key_lane(frame_key, lane), 1'b0, left == '0);
                lane = lane + 2'd1;
                if (left == '0)
                    frame_live = 1'b0;
            end
            return owed_bytes.size() - before_cnt;
        endfunction

        function void check_byte(wsce_out_t got);
            wsce_out_t want;
            if (owed_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, got %h hdr %b eof %b",
                         $time, got.out_byte, got.header_flag, got.end_of_frame);
                fails++;
                return;
            end
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.header_flag !== want.header_flag
                || got.end_of_frame !== want.end_of_frame) begin
                $display("%0t: byte mismatch: expected %h hdr %b eof %b, got %h hdr %b eof %b",
                         $time, want.out_byte, want.header_flag, want.end_of_frame,
                         got.out_byte, got.header_flag, got.end_of_frame);
                fails++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    wsce_in_t  item;
    logic      result_valid;
    logic      result_ready;
    wsce_out_t result;

    frame_tracker board = new();
    bit           steady;
    int           words_done;

    websocket_client_frame_encoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #10 clk = ~clk;

    // Random back-pressure on the output, none during the steady stretch
    initial begin
        result_ready = 1'b0;
        forever begin
            @(negedge clk);
            result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            board.check_byte(result);

    function automatic wsce_in_t rand_word();
        wsce_in_t w;
        w.req_type       = REQ_PAYLOAD;
        w.final_flag     = 1'($urandom_range(1));
        w.frame_opcode   = 4'($urandom_range(15));
        w.payload_length = LEN_W'({$urandom, $urandom});
        w.masking_key    = $urandom;
        w.data_byte      = 8'($urandom_range(255));
        return w;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input wsce_in_t w);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        if (board.note_word(w) > 0)
            words_done++;
        @(negedge clk);
    endtask

    task automatic send_start(input logic fin, input logic [3:0] opc,
                              input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] key);
        wsce_in_t w;
        w                = rand_word();
        w.req_type       = REQ_START;
        w.final_flag     = fin;
        w.frame_opcode   = opc;
        w.payload_length = len;
        w.masking_key    = key;
        send_word(w);
    endtask

    task automatic send_payload(input logic [7:0] d);
        wsce_in_t w;
        w           = rand_word();
        w.req_type  = REQ_PAYLOAD;
        w.data_byte = d;
        send_word(w);
    endtask

    initial begin
        int               pick;
        int               sel;
        logic [LEN_W-1:0] len;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        steady     = 1'b0;
        words_done = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty payload, then a stray byte with no frame open
        send_start(1'b1, OPC_CONT, '0, 32'hFFFF_FFFF);
        send_payload(8'hA5);
        send_start(1'b0, OPC_RSV_F, LEN_W'(1), 32'h0000_0000);
        send_payload(8'hFF);
        send_start(1'b1, OPC_TEXT, LEN7_MAX, 32'h1234_5678);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h5A);
        send_payload(8'hC3);
        send_payload(8'h77);
        // Abandon the open frame with new starts across the length forms
        send_start(1'b1, OPC_BINARY, LEN7_MAX + LEN_W'(1), 32'hA5C3_0F96);
        send_payload(8'h3C);
        send_payload(8'hE1);
        send_start(1'b0, OPC_CLOSE, LEN16_MAX, 32'h8001_7FFE);
        send_start(1'b1, OPC_PING, LEN16_MAX + LEN_W'(1), 32'hDEAD_BEEF);
        send_start(1'b1, OPC_PONG, '1, 32'hFFFF_FFFF);
        send_payload(8'h81);
        send_start(1'b1, OPC_BINARY, LEN_W'(3), 32'h0102_0304);
        send_payload(8'h10);
        send_payload(8'h20);
        send_payload(8'h30);
        send_payload(8'h40);

        while (words_done < WORD_COUNT) begin
            steady = (words_done >= 150) && (words_done < 260);
            pick   = $urandom_range(99);
            if (pick < 70) begin
                // Complete frame, mostly short
                sel = $urandom_range(19);
                if (sel == 0)
                    len = LEN_W'($urandom_range(200, 126));
                else if (sel == 1)
                    len = '0;
                else
                    len = LEN_W'($urandom_range(12, 1));
                send_start(1'($urandom_range(1)), 4'($urandom_range(15)), len, $urandom);
                repeat (len) send_payload(8'($urandom_range(255)));
            end
            else if (pick < 85) begin
                // Frame of any length form, usually cut short by the next start
                sel = $urandom_range(2);
                if (sel == 0)
                    len = LEN_W'($urandom_range(65535, 126));
                else
                    len = LEN_W'({$urandom, $urandom}) >> $urandom_range(62);
                send_start(1'($urandom_range(1)), 4'($urandom_range(15)), len, $urandom);
                repeat ($urandom_range(6)) send_payload(8'($urandom_range(255)));
            end
            else begin
                repeat ($urandom_range(3, 1)) send_payload(8'($urandom_range(255)));
            end
        end
        steady = 1'b0;
        item_valid <= 1'b0;

        while (board.owed_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
